@@ src/sha512_pkg.sv @@
// ----------------------------------------------------------------------------
// sha512_pkg
// Shared types, round constants and functions for the SHA-512 engine.
// ----------------------------------------------------------------------------
package sha512_pkg;

    // block job handed from the byte front end to the compression back end
    typedef struct packed {
        logic [1023:0] block;
        logic          last;   // digest goes out after this block
    } job_t;

    localparam logic [63:0] H_INIT [8] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
        64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
        64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
    };

    localparam logic [63:0] ROUND_K [80] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };

    localparam logic [7:0] PAD_BYTE    = 8'h80;
    localparam logic [6:0] LEN_OFFSET  = 7'd112;

    function automatic logic [63:0] ror64(input logic [63:0] x, input int unsigned n);
        ror64 = (x >> n) | (x << (64 - n));
    endfunction

endpackage

@@ src/sha512_front.sv @@
// ----------------------------------------------------------------------------
// sha512_front
// Packs bytes into 128-byte blocks, counts bits, builds padding blocks and
// hands complete blocks to the job queue.
// ----------------------------------------------------------------------------
module sha512_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          in_byte,
    input  logic                in_present,
    input  logic                in_end,
    output logic                job_valid,
    input  logic                job_ready,
    output sha512_pkg::job_t    job
);

    typedef enum logic [1:0] {ST_BYTES, ST_PAD1, ST_LEN} state_t;

    state_t         state_reg;
    logic [1023:0]  blk_reg;
    logic [6:0]     fill_reg;
    logic [127:0]   bits_reg;
    logic           pend_end_reg;   // byte filled the block and end mark rides along
    logic           job_valid_reg;
    sha512_pkg::job_t job_reg;

    logic [1023:0]  blk_byte;
    logic [1023:0]  blk_pad;
    logic [1023:0]  keep_mask;
    logic [10:0]    pos;

    assign job_valid = job_valid_reg;
    assign job       = job_reg;
    // stall while a job is held or padding is being emitted
    assign in_ready  = (state_reg == ST_BYTES) && !job_valid_reg && !pend_end_reg;

    assign pos = {fill_reg, 3'b000};

    always_comb
    begin
        blk_byte = blk_reg;
        blk_byte[11'd1023 - pos -: 8] = in_byte;
        keep_mask = ~({1024{1'b1}} >> pos);
        blk_pad = (blk_reg & keep_mask) |
                  ({sha512_pkg::PAD_BYTE, 1016'd0} >> pos);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_BYTES;
            fill_reg      <= '0;
            bits_reg      <= '0;
            pend_end_reg  <= 1'b0;
            job_valid_reg <= 1'b0;
        end
        else
        begin
            if (job_valid_reg && job_ready)
            begin
                job_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_BYTES:
                begin
                    if (pend_end_reg && !job_valid_reg)
                    begin
                        pend_end_reg <= 1'b0;
                        state_reg    <= ST_PAD1;
                    end
                    else if (in_valid && in_ready)
                    begin
                        if (in_present)
                        begin
                            blk_reg  <= blk_byte;
                            bits_reg <= bits_reg + 128'd8;
                            fill_reg <= fill_reg + 7'd1;
                            if (fill_reg == 7'd127)
                            begin
                                job_reg.block <= blk_byte;
                                job_reg.last  <= 1'b0;
                                job_valid_reg <= 1'b1;
                                pend_end_reg  <= in_end;
                            end
                            else if (in_end)
                            begin
                                state_reg <= ST_PAD1;
                            end
                        end
                        else if (in_end)
                        begin
                            state_reg <= ST_PAD1;
                        end
                    end
                end
                ST_PAD1:
                begin
                    if (!job_valid_reg)
                    begin
                        job_valid_reg <= 1'b1;
                        if (fill_reg >= sha512_pkg::LEN_OFFSET)
                        begin
                            job_reg.block <= blk_pad;
                            job_reg.last  <= 1'b0;
                            blk_reg       <= '0;
                            state_reg     <= ST_LEN;
                        end
                        else
                        begin
                            job_reg.block <= {blk_pad[1023:128], bits_reg};
                            job_reg.last  <= 1'b1;
                            blk_reg       <= {blk_pad[1023:128], bits_reg};
                            fill_reg      <= '0;
                            bits_reg      <= '0;
                            state_reg     <= ST_BYTES;
                        end
                    end
                end
                ST_LEN:
                begin
                    if (!job_valid_reg)
                    begin
                        job_valid_reg <= 1'b1;
                        job_reg.block <= {896'd0, bits_reg};
                        job_reg.last  <= 1'b1;
                        blk_reg       <= {896'd0, bits_reg};
                        fill_reg      <= '0;
                        bits_reg      <= '0;
                        state_reg     <= ST_BYTES;
                    end
                end
                default:
                begin
                    state_reg <= ST_BYTES;
                end
            endcase
        end
    end

    a_fill_zero_on_pad: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LEN) |-> (fill_reg >= sha512_pkg::LEN_OFFSET))
        else $error("length block without late padding");
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid_reg |-> !in_ready)
        else $error("byte taken while job pending");
    a_pend_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pend_end_reg) |-> (fill_reg == 7'd0) && job_valid_reg)
        else $error("pending end without full block");

endmodule

@@ src/sha512_queue.sv @@
// ----------------------------------------------------------------------------
// sha512_queue
// Two-entry job queue between the front end and the compression back end.
// ----------------------------------------------------------------------------
module sha512_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_valid,
    output logic              wr_ready,
    input  sha512_pkg::job_t  wr_job,
    output logic              rd_valid,
    input  logic              rd_ready,
    output sha512_pkg::job_t  rd_job
);

    sha512_pkg::job_t mem [2];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] cnt_reg;
    logic       wr_fire;
    logic       rd_fire;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_job   = mem[rptr_reg];
    assign wr_fire  = wr_valid && wr_ready;
    assign rd_fire  = rd_valid && rd_ready;

    always_ff @(posedge clk)
    begin
        if (wr_fire)
        begin
            mem[wptr_reg] <= wr_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (wr_fire)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (rd_fire)
            begin
                rptr_reg <= ~rptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, wr_fire} - {1'b0, rd_fire};
        end
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3) else $error("queue count overflow");
    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        ((cnt_reg == 2'd0) || (cnt_reg == 2'd2)) |-> (wptr_reg == rptr_reg))
        else $error("queue pointers out of step");

endmodule

@@ src/sha512_core.sv @@
// ----------------------------------------------------------------------------
// sha512_core
// One SHA-512 round per cycle over a 16-word schedule window, then the
// hash update and, on the last block, eight digest words out.
// ----------------------------------------------------------------------------
module sha512_core
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              job_valid,
    output logic              job_ready,
    input  sha512_pkg::job_t  job,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [63:0]       out_word,
    output logic [2:0]        out_num,
    output logic              out_last
);

    typedef enum logic [1:0] {ST_IDLE, ST_ROUND, ST_ADD, ST_OUT} state_t;

    state_t       state_reg;
    logic [63:0]  h_reg [8];
    logic [63:0]  v_reg [8];
    logic [63:0]  w_reg [16];
    logic [6:0]   rnd_reg;
    logic         last_reg;
    logic [2:0]   idx_reg;
    logic         out_valid_reg;
    logic [63:0]  out_word_reg;

    logic [63:0]  t1, t2, s0, s1, w_new, e, a;

    assign job_ready = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;
    assign out_num   = idx_reg;
    assign out_last  = (idx_reg == 3'd7);

    always_comb
    begin
        e  = v_reg[4];
        a  = v_reg[0];
        t1 = v_reg[7] + (sha512_pkg::ror64(e, 14) ^ sha512_pkg::ror64(e, 18) ^
                         sha512_pkg::ror64(e, 41)) + ((e & v_reg[5]) ^ (~e & v_reg[6])) +
             sha512_pkg::ROUND_K[rnd_reg] + w_reg[0];
        t2 = (sha512_pkg::ror64(a, 28) ^ sha512_pkg::ror64(a, 34) ^ sha512_pkg::ror64(a, 39)) +
             ((a & v_reg[1]) ^ (a & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
        s0 = sha512_pkg::ror64(w_reg[1], 1) ^ sha512_pkg::ror64(w_reg[1], 8) ^ (w_reg[1] >> 7);
        s1 = sha512_pkg::ror64(w_reg[14], 19) ^ sha512_pkg::ror64(w_reg[14], 61) ^
             (w_reg[14] >> 6);
        w_new = s1 + w_reg[9] + s0 + w_reg[0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            h_reg         <= sha512_pkg::H_INIT;
            rnd_reg       <= '0;
            last_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (job_valid)
                    begin
                        for (int i = 0; i < 16; i++)
                        begin
                            w_reg[i] <= job.block[1023 - 64 * i -: 64];
                        end
                        v_reg     <= h_reg;
                        last_reg  <= job.last;
                        rnd_reg   <= '0;
                        state_reg <= ST_ROUND;
                    end
                end
                ST_ROUND:
                begin
                    v_reg[7] <= v_reg[6];
                    v_reg[6] <= v_reg[5];
                    v_reg[5] <= v_reg[4];
                    v_reg[4] <= v_reg[3] + t1;
                    v_reg[3] <= v_reg[2];
                    v_reg[2] <= v_reg[1];
                    v_reg[1] <= v_reg[0];
                    v_reg[0] <= t1 + t2;
                    for (int i = 0; i < 15; i++)
                    begin
                        w_reg[i] <= w_reg[i + 1];
                    end
                    w_reg[15] <= w_new;
                    rnd_reg   <= rnd_reg + 7'd1;
                    if (rnd_reg == 7'd79)
                    begin
                        state_reg <= ST_ADD;
                    end
                end
                ST_ADD:
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        h_reg[i] <= h_reg[i] + v_reg[i];
                    end
                    if (last_reg)
                    begin
                        idx_reg       <= '0;
                        out_word_reg  <= h_reg[0] + v_reg[0];
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_OUT;
                    end
                    else
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_OUT:
                begin
                    if (out_ready)
                    begin
                        if (idx_reg == 3'd7)
                        begin
                            out_valid_reg <= 1'b0;
                            h_reg         <= sha512_pkg::H_INIT;
                            state_reg     <= ST_IDLE;
                        end
                        else
                        begin
                            idx_reg      <= idx_reg + 3'd1;
                            out_word_reg <= h_reg[idx_reg + 3'd1];
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_out_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg == (state_reg == ST_OUT)) else $error("output valid outside output");
    a_round_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND) |-> (rnd_reg < 7'd80)) else $error("round overrun");
    a_hold_word: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> $stable(out_word_reg) && $stable(idx_reg))
        else $error("digest word changed under stall");

endmodule

@@ src/sha512_hash_engine.sv @@
// ----------------------------------------------------------------------------
// sha512_hash_engine
// SHA-512 digest over a byte stream, eight 64-bit digest words per message.
// ----------------------------------------------------------------------------
// Bytes enter one per cycle and fill a 128-byte block; full and padding blocks
// go through a two-entry queue to a compression unit that runs one round per
// cycle: each block is loaded, run through 80 rounds and added into the hash.
// The front end holds off input after each full block while it hands the
// block over, and the round loop keeps up with sustained input. Input also
// stalls while the queue is full, while padding blocks are built after an
// end mark, and behind digest output. After an end mark one or two padding
// blocks run, then the digest streams out MSW first, one word per accepted
// cycle.
module sha512_hash_engine
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // byte_present
    input  logic        s_tlast,   // message_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [63:0] digest_word
    output logic [2:0]  m_tuser,   // [2:0] word_number
    output logic        m_tlast    // final_word
);

    logic             fq_valid;
    logic             fq_ready;
    sha512_pkg::job_t fq_job;
    logic             qc_valid;
    logic             qc_ready;
    sha512_pkg::job_t qc_job;

    sha512_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_byte    (s_tdata),
        .in_present (s_tuser),
        .in_end     (s_tlast),
        .job_valid  (fq_valid),
        .job_ready  (fq_ready),
        .job        (fq_job)
    );

    sha512_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_job   (fq_job),
        .rd_valid (qc_valid),
        .rd_ready (qc_ready),
        .rd_job   (qc_job)
    );

    sha512_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (qc_valid),
        .job_ready (qc_ready),
        .job       (qc_job),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_word  (m_tdata),
        .out_num   (m_tuser),
        .out_last  (m_tlast)
    );

endmodule
